@@ hdl/vad_pkg.sv @@
// Shared types, constants and arctangent table of the vector angle pipeline.
package vad_pkg;

  localparam int unsigned CODE_W    = 16;
  localparam int unsigned ACC_W     = 25;
  localparam int unsigned THETA_W   = 23;
  localparam int unsigned FINE_W    = 26;
  localparam int unsigned ATAN_W    = 22;
  localparam int unsigned ATAN_LEN  = 24;
  localparam int unsigned OUT_SHIFT = 9;

  localparam int unsigned FINE_90    = 90 * 65536;
  localparam int unsigned FINE_180   = 180 * 65536;
  localparam int unsigned FINE_360   = 360 * 65536;
  localparam int unsigned ROUND_HALF = 1 << (OUT_SHIFT - 1);

  localparam int unsigned CODE_90   = 90 * 128;
  localparam int unsigned CODE_180  = 180 * 128;
  localparam int unsigned CODE_270  = 270 * 128;
  localparam int unsigned CODE_FULL = 360 * 128;

  localparam logic [ATAN_W-1:0] ATAN_FINE [0:ATAN_LEN-1] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef struct packed {
    logic              x_neg;
    logic              y_neg;
    logic              axis;
    logic [CODE_W-1:0] axis_code;
  } vad_quad_t;

endpackage

@@ hdl/vad_vec_if.sv @@
// Handshake channel carrying one signed vector per word.
interface vad_vec_if #(
  parameter int unsigned COORD_WIDTH = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] x_coord;
  logic signed [COORD_WIDTH-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

@@ hdl/vad_angle_if.sv @@
// Handshake channel carrying one angle code per word.
interface vad_angle_if;
  logic                        valid;
  logic                        ready;
  logic [vad_pkg::CODE_W-1:0]  angle_code;

  modport source (output valid, output angle_code, input ready);
  modport sink   (input valid, input angle_code, output ready);
endinterface

@@ hdl/vad_fold.sv @@
// Input stage: fold the vector into the first quadrant and flag axis cases.
module vad_fold #(
  parameter int unsigned CW = 16,
  parameter int unsigned RS = 16,
  parameter int unsigned W  = CW + RS + 3
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [CW-1:0]   x_i,
  input  logic signed [CW-1:0]   y_i,
  output logic                   valid_o,
  output logic signed [W-1:0]    px_o,
  output logic signed [W-1:0]    py_o,
  output vad_pkg::vad_quad_t     quad_o
);
  import vad_pkg::*;

  logic signed [W-1:0] x_ext, y_ext, ax, ay;
  logic signed [W-1:0] px_d, py_d, px_q, py_q;
  vad_quad_t           quad_d, quad_q;
  logic                valid_q;

  always_comb begin
    x_ext = {{(W-CW){x_i[CW-1]}}, x_i};
    y_ext = {{(W-CW){y_i[CW-1]}}, y_i};
    ax    = x_i[CW-1] ? -x_ext : x_ext;
    ay    = y_i[CW-1] ? -y_ext : y_ext;
    px_d  = ax <<< RS;
    py_d  = ay <<< RS;
    quad_d.x_neg = x_i[CW-1];
    quad_d.y_neg = y_i[CW-1];
    quad_d.axis  = (x_i == '0) || (y_i == '0);
    if (y_i == '0) begin
      quad_d.axis_code = x_i[CW-1] ? CODE_W'(CODE_180) : '0;
    end else begin
      quad_d.axis_code = y_i[CW-1] ? CODE_W'(CODE_270) : CODE_W'(CODE_90);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= px_d;
      py_q   <= py_d;
      quad_q <= quad_d;
    end
  end

  assign valid_o = valid_q;
  assign px_o    = px_q;
  assign py_o    = py_q;
  assign quad_o  = quad_q;

  a_folded_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !quad_q.axis) |->
      (!px_q[W-1] && (px_q != '0) && !py_q[W-1] && (py_q != '0)))
    else $error("folded vector not in first quadrant");
endmodule

@@ hdl/vad_rot_stage.sv @@
// One micro-rotation stage of the vectoring pipeline.
module vad_rot_stage #(
  parameter int unsigned STEP = 0,
  parameter int unsigned W    = 35
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [W-1:0]                px_i,
  input  logic signed [W-1:0]                py_i,
  input  logic signed [vad_pkg::ACC_W-1:0]   acc_i,
  input  vad_pkg::vad_quad_t                 quad_i,
  output logic                               valid_o,
  output logic signed [W-1:0]                px_o,
  output logic signed [W-1:0]                py_o,
  output logic signed [vad_pkg::ACC_W-1:0]   acc_o,
  output vad_pkg::vad_quad_t                 quad_o
);
  import vad_pkg::*;

  localparam logic signed [ACC_W-1:0] ATAN_STEP = ACC_W'(ATAN_FINE[STEP]);

  logic signed [W-1:0]     dx, dy, px_d, py_d, px_q, py_q;
  logic signed [ACC_W-1:0] acc_d, acc_q;
  vad_quad_t               quad_q;
  logic                    valid_q;

  always_comb begin
    dx = py_i >>> STEP;
    dy = px_i >>> STEP;
    if (!py_i[W-1] && (py_i != '0)) begin
      px_d  = px_i + dx;
      py_d  = py_i - dy;
      acc_d = acc_i + ATAN_STEP;
    end else begin
      px_d  = px_i - dx;
      py_d  = py_i + dy;
      acc_d = acc_i - ATAN_STEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q   <= px_d;
      py_q   <= py_d;
      acc_q  <= acc_d;
      quad_q <= quad_i;
    end
  end

  assign valid_o = valid_q;
  assign px_o    = px_q;
  assign py_o    = py_q;
  assign acc_o   = acc_q;
  assign quad_o  = quad_q;
endmodule

@@ hdl/vad_finish.sv @@
// Output stages: clamp, map to the true quadrant, round and wrap the angle, or pass the axis code.
module vad_finish (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic signed [vad_pkg::ACC_W-1:0]   acc_i,
  input  vad_pkg::vad_quad_t                 quad_i,
  output logic                               valid_o,
  output logic [vad_pkg::CODE_W-1:0]         code_o
);
  import vad_pkg::*;

  logic [THETA_W-1:0]  theta;
  logic [FINE_W-1:0]   fine_d, fine_q, rounded;
  logic [FINE_W-OUT_SHIFT-1:0] code_wide;
  logic [CODE_W-1:0]   code_d, code_q;
  logic                axis_q;
  logic [CODE_W-1:0]   axis_code_q;
  logic                fine_valid_q, valid_q;

  always_comb begin
    if (acc_i[ACC_W-1]) begin
      theta = '0;
    end else if (acc_i > ACC_W'(FINE_90)) begin
      theta = THETA_W'(FINE_90);
    end else begin
      theta = acc_i[THETA_W-1:0];
    end
    case ({quad_i.x_neg, quad_i.y_neg})
      2'b00:   fine_d = FINE_W'(theta);
      2'b10:   fine_d = FINE_W'(FINE_180) - FINE_W'(theta);
      2'b11:   fine_d = FINE_W'(FINE_180) + FINE_W'(theta);
      default: fine_d = FINE_W'(FINE_360) - FINE_W'(theta);
    endcase
  end

  always_comb begin
    rounded   = fine_q + FINE_W'(ROUND_HALF);
    code_wide = rounded[FINE_W-1:OUT_SHIFT];
    if (axis_q) begin
      code_d = axis_code_q;
    end else if (code_wide >= (FINE_W-OUT_SHIFT)'(CODE_FULL)) begin
      code_d = CODE_W'(code_wide - (FINE_W-OUT_SHIFT)'(CODE_FULL));
    end else begin
      code_d = code_wide[CODE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fine_valid_q <= 1'b0;
      valid_q      <= 1'b0;
    end else if (en_i) begin
      fine_valid_q <= valid_i;
      valid_q      <= fine_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fine_q      <= fine_d;
      axis_q      <= quad_i.axis;
      axis_code_q <= quad_i.axis_code;
      code_q      <= code_d;
    end
  end

  assign valid_o = valid_q;
  assign code_o  = code_q;

  a_fine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fine_valid_q && !axis_q) |-> (fine_q <= FINE_W'(FINE_360)))
    else $error("full-circle angle out of range");
endmodule

@@ hdl/vector_angle_degrees.sv @@
// Top level of the pipelined vector angle unit.
//
//  channel | dir | payload                     | handshake
//  in_i    | in  | x_coord, y_coord (signed)   | valid/ready, word taken on both high
//  out_o   | out | angle_code (1/128 degree)   | valid/ready, word taken on both high
//
// Stages in order: fold stage, one stage per micro-rotation, then clamp/map and
// round/wrap stages. One word enters per cycle while out_o is not stalled.
// Reset clears only the valid bits of the stages.
// A stall on out_o freezes every stage at once; in_i.ready drops only then.
module vector_angle_degrees #(
  parameter int unsigned COORD_WIDTH    = 16,
  parameter int unsigned ROTATION_STEPS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  vad_vec_if.sink     in_i,
  vad_angle_if.source out_o
);
  import vad_pkg::*;

  localparam int unsigned W = COORD_WIDTH + ROTATION_STEPS + 3;

  logic                    en;
  logic                    valid_s [0:ROTATION_STEPS];
  logic signed [W-1:0]     px_s    [0:ROTATION_STEPS];
  logic signed [W-1:0]     py_s    [0:ROTATION_STEPS];
  logic signed [ACC_W-1:0] acc_s   [0:ROTATION_STEPS];
  vad_quad_t               quad_s  [0:ROTATION_STEPS];

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign acc_s[0]   = '0;

  vad_fold #(
    .CW (COORD_WIDTH),
    .RS (ROTATION_STEPS),
    .W  (W)
  ) u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .x_i     (in_i.x_coord),
    .y_i     (in_i.y_coord),
    .valid_o (valid_s[0]),
    .px_o    (px_s[0]),
    .py_o    (py_s[0]),
    .quad_o  (quad_s[0])
  );

  for (genvar i = 0; i < ROTATION_STEPS; i++) begin : g_rot
    vad_rot_stage #(
      .STEP (i),
      .W    (W)
    ) u_rot (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid_s[i]),
      .px_i    (px_s[i]),
      .py_i    (py_s[i]),
      .acc_i   (acc_s[i]),
      .quad_i  (quad_s[i]),
      .valid_o (valid_s[i+1]),
      .px_o    (px_s[i+1]),
      .py_o    (py_s[i+1]),
      .acc_o   (acc_s[i+1]),
      .quad_o  (quad_s[i+1])
    );
  end

  vad_finish u_finish (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_s[ROTATION_STEPS]),
    .acc_i   (acc_s[ROTATION_STEPS]),
    .quad_i  (quad_s[ROTATION_STEPS]),
    .valid_o (out_o.valid),
    .code_o  (out_o.angle_code)
  );

  a_stall_only_on_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_o.valid && !out_o.ready))
    else $error("input stalled while output free");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.angle_code < CODE_W'(CODE_FULL)))
    else $error("angle code beyond full circle");
endmodule
